FILE: src/ewlz_pkg.sv
// Package for the escape-word LZ word decoder.
// Holds item codes, status codes, parser phases and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ewlz_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned PosW  = 15;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_WORD = 2'd1,
    KIND_STEP = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_LITERAL  = 2'd0,
    ST_COPIED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_COUNT  = 2'd2,
    PH_LOC    = 2'd3
  } phase_e;

  localparam logic [WordW-1:0] EscMin   = 16'hfff0;
  localparam logic [WordW-1:0] EscDflt  = 16'hffff;
  localparam logic [WordW-1:0] RefFlag  = 16'h8000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PosW-1:0]  ref_addr;
    logic [WordW-1:0] word;
    logic             final_word;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic [PosW-1:0]  out_pos;
    logic [1:0]       out_status;
    logic             run_last;
  } out_item_t;

endpackage
`default_nettype wire

FILE: src/ewlz_if.sv
// Valid/ready channel interfaces for the escape-word LZ decoder.
// No dependencies; field widths are written out as literals.
`timescale 1ns / 1ps
`default_nettype none
interface ewlz_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [14:0] ref_addr;
  logic [15:0] word;
  logic        final_word;
  modport source (output valid, kind, ref_addr, word, final_word, input ready);
  modport sink   (input valid, kind, ref_addr, word, final_word, output ready);
endinterface

interface ewlz_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic [14:0] out_pos;
  logic [1:0]  out_status;
  logic        run_last;
  modport source (output valid, out_word, out_pos, out_status, run_last, input ready);
  modport sink   (input valid, out_word, out_pos, out_status, run_last, output ready);
endinterface
`default_nettype wire

FILE: src/ewlz_queue.sv
// Two-entry queue between front and back of the decoder.
// Depends on ewlz_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module ewlz_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ewlz_pkg::in_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ewlz_pkg::in_item_t pop_data_o
);
  import ewlz_pkg::*;

  in_item_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

FILE: src/ewlz_back.sv
// Back part: parser, copy engine, history and reference memories.
// Depends on ewlz_pkg. Issues one item per cycle unless stalled; the
// result leaves via a registered read stage and a two-entry buffer.
`timescale 1ns / 1ps
`default_nettype none
module ewlz_back #(
  parameter int unsigned OUT_DEPTH = 32768,
  parameter int unsigned REF_DEPTH = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  ewlz_pkg::in_item_t item_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output ewlz_pkg::out_item_t res_o
);
  import ewlz_pkg::*;

  localparam int unsigned HistAw = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned RefAw  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam logic [16:0] OutLim = 17'(OUT_DEPTH);
  localparam logic [15:0] RefLim = 16'(REF_DEPTH);

  logic [WordW-1:0] hist_mem [OUT_DEPTH];
  logic [WordW-1:0] ref_mem  [REF_DEPTH];

  phase_e     phase_q, phase_d;
  logic [15:0] esc_q, esc_d, runlen_q, runlen_d, remain_q, remain_d, src_q, src_d;
  logic [16:0] wpos_q, wpos_d;

  // output buffer: two entries, so one result may sit in stage 1 while
  // another waits in the buffer; issue only when a free slot is certain
  out_item_t  ob_q [2];
  logic       ob_wp_q, ob_rp_q;
  logic [1:0] ob_cnt_q;

  // read stage
  logic       s1_vld_q, s1_mem_q, s1_ref_q;
  out_item_t  s1_q;

  logic       issue, res_vld, res_mem, res_ref, hist_we, ref_we;
  out_item_t  res;
  logic [15:0] idx;
  logic        ok;
  logic [WordW-1:0] rd_data;
  logic        ob_push, ob_pop;

  assign issue = !empty_i && ((32'(ob_cnt_q) + 32'(s1_vld_q)) < 2 ||
                 ((32'(ob_cnt_q) + 32'(s1_vld_q)) == 2 && res_ready_i && ob_cnt_q != 0));
  assign pop_o = issue;
  assign idx   = {1'b0, src_q[14:0]};

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    runlen_d = runlen_q;
    remain_d = remain_q;
    src_d    = src_q;
    wpos_d   = wpos_q;
    res_vld  = 1'b0;
    res_mem  = 1'b0;
    res_ref  = 1'b0;
    hist_we  = 1'b0;
    ref_we   = 1'b0;
    ok       = 1'b0;
    res      = '0;
    res.out_pos = wpos_q[14:0];
    if (issue) begin
      case (item_i.kind)
        KIND_LOAD: begin
          if ({1'b0, item_i.ref_addr} < RefLim) ref_we = 1'b1;
          else begin
            res_vld = 1'b1;
            res = '{item_i.word, item_i.ref_addr, ST_REJECTED, 1'b0};
          end
        end
        KIND_WORD: begin
          if (remain_q != '0) begin
            res_vld = 1'b1;
            res = '{item_i.word, wpos_q[14:0], ST_REJECTED, 1'b0};
          end else begin
            case (phase_q)
              PH_HEADER: begin
                wpos_d  = '0;
                phase_d = PH_DATA;
                if (item_i.word >= EscMin) esc_d = item_i.word;
                else begin
                  esc_d   = EscDflt;
                  res_vld = 1'b1;
                  res     = '{item_i.word, 15'd0, ST_LITERAL, 1'b1};
                  hist_we = 1'b1;
                  wpos_d  = 17'd1;
                end
              end
              PH_DATA: begin
                if (item_i.word == esc_q) phase_d = PH_COUNT;
                else begin
                  res_vld = 1'b1;
                  if (wpos_q >= OutLim) res = '{item_i.word, wpos_q[14:0], ST_FULL, 1'b1};
                  else begin
                    res = '{item_i.word, wpos_q[14:0], ST_LITERAL, 1'b1};
                    hist_we = 1'b1;
                    wpos_d  = wpos_q + 17'd1;
                  end
                end
              end
              PH_COUNT: begin
                runlen_d = item_i.word;
                phase_d  = PH_LOC;
              end
              default: begin
                src_d    = item_i.word;
                remain_d = runlen_q;
                phase_d  = PH_DATA;
              end
            endcase
            if (item_i.final_word) phase_d = PH_HEADER;
          end
        end
        KIND_STEP: begin
          if (remain_q != '0) begin
            remain_d = remain_q - 16'd1;
            res_vld  = 1'b1;
            res.run_last = (remain_q == 16'd1);
            if ((src_q & RefFlag) != '0) ok = idx < RefLim;
            else ok = ({1'b0, idx} < wpos_q) && ({1'b0, idx} < OutLim);
            src_d = {src_q[15], src_q[14:0] + 15'd1};
            if (!ok) res.out_status = ST_REJECTED;
            else begin
              res_mem = 1'b1;
              res_ref = src_q[15];
              if (wpos_q >= OutLim) res.out_status = ST_FULL;
              else begin
                res.out_status = ST_COPIED;
                hist_we = 1'b1;
                wpos_d  = wpos_q + 17'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // history writes land the cycle after issue, ref loads at issue;
  // a copy's history write takes the word from the read stage
  logic              cw_q;
  logic              lw_q;
  logic [HistAw-1:0] lw_addr_q;
  logic [WordW-1:0]  lw_data_q;
  logic [WordW-1:0]  s1_word;
  logic              byp_q;
  logic [WordW-1:0]  byp_data_q;

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[item_i.ref_addr[RefAw-1:0]] <= item_i.word;
    rd_data <= res_ref ? ref_mem[idx[RefAw-1:0]] : hist_mem[idx[HistAw-1:0]];
    if (lw_q) hist_mem[lw_addr_q] <= lw_data_q;
    else if (cw_q) hist_mem[lw_addr_q] <= s1_word;
    s1_q   <= res;
    lw_data_q <= item_i.word;
    lw_addr_q <= res.out_pos[HistAw-1:0];
  end

  // forward a pending literal or copy write to a read of the same entry
  always_ff @(posedge clk_i) begin
    byp_q      <= (lw_q || cw_q) && !res_ref && (lw_addr_q == idx[HistAw-1:0]);
    byp_data_q <= lw_q ? lw_data_q : s1_word;
  end

  always_comb begin
    s1_word = s1_q.out_word;
    if (s1_mem_q) s1_word = (byp_q && !s1_ref_q) ? byp_data_q : rd_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      esc_q    <= EscDflt;
      runlen_q <= '0;
      remain_q <= '0;
      src_q    <= '0;
      wpos_q   <= '0;
      s1_vld_q <= 1'b0;
      s1_mem_q <= 1'b0;
      s1_ref_q <= 1'b0;
      lw_q     <= 1'b0;
      cw_q     <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      runlen_q <= runlen_d;
      remain_q <= remain_d;
      src_q    <= src_d;
      wpos_q   <= wpos_d;
      s1_vld_q <= res_vld;
      s1_mem_q <= res_mem;
      s1_ref_q <= res_ref;
      lw_q     <= hist_we && !res_mem;
      cw_q     <= hist_we && res_mem;
    end
  end

  assign ob_push     = s1_vld_q;
  assign res_valid_o = (ob_cnt_q != 2'd0);
  assign res_o       = ob_q[ob_rp_q];
  assign ob_pop      = res_valid_o && res_ready_i;

  always_ff @(posedge clk_i) begin
    if (ob_push) ob_q[ob_wp_q] <= '{s1_word, s1_q.out_pos, s1_q.out_status, s1_q.run_last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wp_q <= 1'b0; ob_rp_q <= 1'b0; ob_cnt_q <= 2'd0;
    end else begin
      if (ob_push) ob_wp_q <= ~ob_wp_q;
      if (ob_pop)  ob_rp_q <= ~ob_rp_q;
      ob_cnt_q <= ob_cnt_q + 2'(ob_push) - 2'(ob_pop);
    end
  end
endmodule
`default_nettype wire

FILE: src/escape_word_lz_decoder.sv
// Top level of the escape-word LZ word decoder.
// Depends on ewlz_pkg, ewlz_if, ewlz_queue and ewlz_back.
//
//   channel  dir  payload
//   in_ch    in   kind, ref_addr, word, final_word
//   out_ch   out  out_word, out_pos, out_status, run_last
//
// One transaction per cycle sustained while the output is ready; the back part
// issues one item a cycle from the queue while the output buffer has room; an
// input reaches the result through the queue, the memory read stage and the
// output buffer, each registered. Reset is asynchronous, active low, and
// clears control state only; the memories are undefined until written. A
// stalled output fills the output buffer, then the queue, then drops ready.
`timescale 1ns / 1ps
`default_nettype none
module escape_word_lz_decoder #(
  parameter int unsigned OUT_DEPTH = 32768,
  parameter int unsigned REF_DEPTH = 32768
) (
  input  logic clk_i,
  input  logic rst_ni,
  ewlz_in_if.sink    in_ch,
  ewlz_out_if.source out_ch
);
  import ewlz_pkg::*;

  in_item_t  q_in, q_out;
  out_item_t res;
  logic      q_full, q_empty, pop, push;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign q_in        = '{in_ch.kind, in_ch.ref_addr, in_ch.word, in_ch.final_word};

  ewlz_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(q_in), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .pop_data_o(q_out)
  );

  ewlz_back #(.OUT_DEPTH(OUT_DEPTH), .REF_DEPTH(REF_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .empty_i(q_empty), .item_i(q_out), .pop_o(pop),
    .res_valid_o(out_ch.valid), .res_ready_i(out_ch.ready), .res_o(res)
  );

  assign out_ch.out_word   = res.out_word;
  assign out_ch.out_pos    = res.out_pos;
  assign out_ch.out_status = res.out_status;
  assign out_ch.run_last   = res.run_last;

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("pop from empty queue");
  // a full queue blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> !in_ch.ready)
    else $error("ready with full queue");
  // a held result keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.out_word))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

FILE: tb/escape_word_lz_decoder_tb.sv
// Self-checking testbench for the escape-word LZ word decoder.
// Depends on ewlz_pkg, ewlz_if and the escape_word_lz_decoder RTL.
// Drives load, stream, step and ignored transactions; checks every result.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the decoder state transaction by transaction and holds the words
// that the block owes us, oldest first.
class ewlz_scoreboard;
  logic [15:0]     hist_mem [32768];
  logic [15:0]     ref_mem  [32768];
  bit              ref_loaded [32768];
  ewlz_pkg::phase_e phase;
  logic [15:0]     esc_word;
  int unsigned     run_len;
  int unsigned     copy_left;
  logic [15:0]     copy_src;
  int unsigned     wr_pos;
  int unsigned     out_depth;
  int unsigned     ref_depth;
  int unsigned     n_errors;
  ewlz_pkg::out_item_t pending_words [$];

  function new(int unsigned od, int unsigned rd);
    out_depth = od;
    ref_depth = rd;
    phase     = ewlz_pkg::PH_HEADER;
    esc_word  = ewlz_pkg::EscDflt;
    run_len   = 0;
    copy_left = 0;
    copy_src  = '0;
    wr_pos    = 0;
    n_errors  = 0;
  endfunction

  function void owe(logic [15:0] w, int unsigned pos, ewlz_pkg::status_e st, bit last);
    ewlz_pkg::out_item_t r;
    r.out_word   = w;
    r.out_pos    = pos[14:0];
    r.out_status = st;
    r.run_last   = last;
    pending_words.push_back(r);
  endfunction

  function void put_literal(logic [15:0] w);
    if (wr_pos >= out_depth) begin
      owe(w, wr_pos, ewlz_pkg::ST_FULL, 1'b1);
    end else begin
      hist_mem[wr_pos] = w;
      owe(w, wr_pos, ewlz_pkg::ST_LITERAL, 1'b1);
      wr_pos++;
    end
  endfunction

  // Advance the decoder state by one accepted input transaction.
  function void note_input(ewlz_pkg::in_item_t it);
    int unsigned idx;
    bit          last;
    bit          ok;
    logic [15:0] val;
    case (it.kind)
      ewlz_pkg::KIND_LOAD: begin
        if (it.ref_addr < ref_depth) begin
          ref_mem[it.ref_addr]    = it.word;
          ref_loaded[it.ref_addr] = 1'b1;
        end else begin
          owe(it.word, it.ref_addr, ewlz_pkg::ST_REJECTED, 1'b0);
        end
      end
      ewlz_pkg::KIND_WORD: begin
        if (copy_left != 0) begin
          // busy: the word is not consumed, final is ignored
          owe(it.word, wr_pos, ewlz_pkg::ST_REJECTED, 1'b0);
        end else begin
          case (phase)
            ewlz_pkg::PH_HEADER: begin
              wr_pos = 0;
              phase  = ewlz_pkg::PH_DATA;
              if (it.word >= ewlz_pkg::EscMin) begin
                esc_word = it.word;
              end else begin
                esc_word = ewlz_pkg::EscDflt;
                put_literal(it.word);
              end
            end
            ewlz_pkg::PH_DATA: begin
              if (it.word == esc_word) phase = ewlz_pkg::PH_COUNT;
              else put_literal(it.word);
            end
            ewlz_pkg::PH_COUNT: begin
              run_len = it.word;
              phase   = ewlz_pkg::PH_LOC;
            end
            default: begin
              copy_src  = it.word;
              copy_left = run_len;
              phase     = ewlz_pkg::PH_DATA;
            end
          endcase
          if (it.final_word) phase = ewlz_pkg::PH_HEADER;
        end
      end
      ewlz_pkg::KIND_STEP: begin
        if (copy_left != 0) begin
          idx = copy_src[14:0];
          copy_left--;
          last = (copy_left == 0);
          val  = '0;
          if (copy_src[15]) begin
            ok = idx < ref_depth;
            if (ok) val = ref_mem[idx];
          end else begin
            ok = idx < wr_pos && idx < out_depth;
            if (ok) val = hist_mem[idx];
          end
          copy_src[14:0] = copy_src[14:0] + 15'd1;
          if (!ok) begin
            owe('0, wr_pos, ewlz_pkg::ST_REJECTED, last);
          end else if (wr_pos >= out_depth) begin
            owe(val, wr_pos, ewlz_pkg::ST_FULL, last);
          end else begin
            hist_mem[wr_pos] = val;
            owe(val, wr_pos, ewlz_pkg::ST_COPIED, last);
            wr_pos++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(ewlz_pkg::out_item_t got);
    ewlz_pkg::out_item_t exp_r;
    if (pending_words.size() == 0) begin
      $error("unexpected result: word %h pos %0d status %0d last %0b",
             got.out_word, got.out_pos, got.out_status, got.run_last);
      n_errors++;
      return;
    end
    exp_r = pending_words.pop_front();
    if (got.out_word !== exp_r.out_word) begin
      $error("out_word: expected %h, got %h", exp_r.out_word, got.out_word);
      n_errors++;
    end
    if (got.out_pos !== exp_r.out_pos) begin
      $error("out_pos: expected %0d, got %0d", exp_r.out_pos, got.out_pos);
      n_errors++;
    end
    if (got.out_status !== exp_r.out_status) begin
      $error("out_status: expected %0d, got %0d", exp_r.out_status, got.out_status);
      n_errors++;
    end
    if (got.run_last !== exp_r.run_last) begin
      $error("run_last: expected %0b, got %0b", exp_r.run_last, got.run_last);
      n_errors++;
    end
  endfunction
endclass

module escape_word_lz_decoder_tb;
  import ewlz_pkg::*;

  localparam int unsigned OutDepth   = 32768;
  localparam int unsigned RefDepth   = 32768;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseItems = 483;

  logic clk_i;
  logic rst_ni;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned cycle_cnt;

  ewlz_scoreboard sb;

  ewlz_in_if  in_ch ();
  ewlz_out_if out_ch ();

  escape_word_lz_decoder #(
    .OUT_DEPTH(OutDepth),
    .REF_DEPTH(RefDepth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("escape_word_lz_decoder_tb: FAIL");
      $finish;
    end
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check each result transaction against the oldest owed word.
  always @(posedge clk_i) begin
    out_item_t got;
    if (rst_ni && sb != null && out_ch.valid && out_ch.ready) begin
      got.out_word   = out_ch.out_word;
      got.out_pos    = out_ch.out_pos;
      got.out_status = out_ch.out_status;
      got.run_last   = out_ch.run_last;
      sb.check_result(got);
    end
  end

  // Offer one transaction, hold it until accepted, then update the state.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.ref_addr   <= it.ref_addr;
    in_ch.word       <= it.word;
    in_ch.final_word <= it.final_word;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic send_fields(input kind_e k, input logic [14:0] a,
                             input logic [15:0] w, input logic f);
    in_item_t it;
    it.kind       = k;
    it.ref_addr   = a;
    it.word       = w;
    it.final_word = f;
    send_item(it);
  endtask

  // True when every reference entry the copy run will touch has been loaded.
  function automatic bit ref_run_loaded(logic [14:0] start, int unsigned len);
    logic [14:0] a;
    a = start;
    for (int unsigned i = 0; i < len; i++) begin
      if (!sb.ref_loaded[a]) return 1'b0;
      a = a + 15'd1;
    end
    return 1'b1;
  endfunction

  // Build one random transaction from where the parser currently stands:
  // mostly well-formed streams, with noise and broken sequences mixed in.
  task automatic send_random_item();
    in_item_t    it;
    int unsigned r;
    logic [14:0] src;
    r             = $urandom_range(99);
    it.kind       = KIND_WORD;
    it.ref_addr   = 15'($urandom);
    it.word       = 16'($urandom);
    it.final_word = ($urandom_range(99) < 4);
    if (r < 5) begin
      it.kind = KIND_LOAD;
      // keep the low window well stocked for reference copies
      if ($urandom_range(1)) it.ref_addr = 15'($urandom_range(127));
    end else if (r < 7) begin
      it.kind = KIND_NONE;
    end else if (sb.copy_left != 0) begin
      // mostly step the run, occasionally poke a stream word in while busy
      if (r < 85) it.kind = KIND_STEP;
    end else if (r < 10) begin
      it.kind = KIND_STEP;
    end else begin
      case (sb.phase)
        PH_HEADER: begin
          if ($urandom_range(1)) it.word = 16'($urandom_range(16'hffff, 16'hfff0));
          it.final_word = 1'b0;
        end
        PH_DATA: begin
          if ($urandom_range(99) < 25) it.word = sb.esc_word;
          else if ($urandom_range(99) < 10) it.word = 16'($urandom_range(16'hffff, 16'hfff0));
        end
        PH_COUNT: begin
          if ($urandom_range(99) < 85) it.word = 16'($urandom_range(12));
          else if ($urandom_range(1)) it.word = 16'($urandom_range(40));
        end
        default: begin
          it.final_word = ($urandom_range(99) < 10);
          if ($urandom_range(99) < 40) begin
            src = $urandom_range(1) ? 15'($urandom_range(127))
                                    : 15'($urandom_range(32767, 32740));
            if (ref_run_loaded(src, sb.run_len)) it.word = {1'b1, src};
            else it.word = {1'b0, src};
          end else if ($urandom_range(99) < 80) begin
            it.word = 16'($urandom_range(sb.wr_pos + 2));
          end else begin
            it.word = {1'b0, 15'($urandom)};
          end
        end
      endcase
    end
    send_item(it);
  endtask

  task automatic wait_drained();
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    sb               = new(OutDepth, RefDepth);
    cycle_cnt        = 0;
    tx_idle_pct      = 19;
    rx_idle_pct      = 66;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_NONE;
    in_ch.ref_addr   = '0;
    in_ch.word       = '0;
    in_ch.final_word = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reference wrap, busy rejection, escape header,
    // zero count, truncated escape, ignored kind and idle step.
    send_fields(KIND_LOAD, 15'h7fff, 16'hffff, 1'b0);
    send_fields(KIND_LOAD, 15'h0000, 16'h0000, 1'b0);
    send_fields(KIND_LOAD, 15'h0001, 16'ha5a5, 1'b0);
    send_fields(KIND_LOAD, 15'h0002, 16'h5a5a, 1'b0);
    send_fields(KIND_NONE, 15'h7fff, 16'hffff, 1'b1);
    send_fields(KIND_STEP, 15'h0000, 16'h0000, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h1234, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'hffff, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h0003, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'hffff, 1'b0);
    send_fields(KIND_STEP, 15'h0000, 16'h0000, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h4321, 1'b1);
    send_fields(KIND_STEP, 15'h0000, 16'h0000, 1'b0);
    send_fields(KIND_STEP, 15'h0000, 16'h0000, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h0000, 1'b1);
    send_fields(KIND_WORD, 15'h0000, 16'hfff0, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'hffff, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'hfff0, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h0004, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h0000, 1'b0);
    repeat (4) send_fields(KIND_STEP, 15'h0000, 16'h0000, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'hfff0, 1'b0);
    send_fields(KIND_WORD, 15'h0000, 16'h0000, 1'b1);

    // Random part in three idling phases.
    repeat (PhaseItems) send_random_item();
    tx_idle_pct = 66;
    rx_idle_pct = 19;
    repeat (PhaseItems) send_random_item();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PhaseItems) send_random_item();

    in_ch.valid <= 1'b0;
    wait_drained();
    if (sb.n_errors == 0) begin
      $display("escape_word_lz_decoder_tb: PASS");
    end else begin
      $display("escape_word_lz_decoder_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
